FILE: sv/mph_pkg.sv
package mph_pkg;

	localparam int PATTERN_BYTES_DEF = 8;

	localparam int BYTE_W    = 8;
	localparam int ADDR_W    = 16;
	localparam int CFG_W     = 64;
	localparam int LEN_W     = 4;
	localparam int CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd2;

	localparam logic [CFG_W-1:0] PATTERN_RST = '0;
	localparam logic [CFG_W-1:0] MASK_RST    = '1;
	localparam logic [LEN_W-1:0] LENGTH_RST  = 4'd1;

	typedef struct packed {
		logic [BYTE_W-1:0] mem_byte;
		logic [ADDR_W-1:0] byte_addr;
		logic              last_byte;
	} byte_beat_t;

	typedef struct packed {
		logic              match_found;
		logic [ADDR_W-1:0] match_addr;
	} hit_beat_t;

	typedef struct packed {
		logic [CFG_W-1:0] pattern_bytes;
		logic [CFG_W-1:0] mask_bytes;
	} cmp_cfg_t;

endpackage

FILE: sv/mph_stream_if.sv
interface mph_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/masked_pattern_hunt.sv
// Channel  Dir  Payload                                Beat
// bytes    in   mem_byte[8], byte_addr[16], last_byte   one memory byte
// hits     out  match_found, match_addr[16]             one window result
// cfg_*    in   cfg_we, cfg_idx[2], cfg_wdata[64]       one register write
//
// One byte per cycle unless hits stalls; stage 1 feeds the result reg.
// The rate is set by the window shift register, updated once per beat.
// Reset clears the window, fill count and config to their defaults.
// A stalled hits channel holds the result register; bytes keeps flowing
// as long as the stage-1 register can move or holds no result.
module masked_pattern_hunt
	import mph_pkg::*;
#(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	mph_stream_if.sink           bytes,
	mph_stream_if.source         hits
);

	localparam int WIN_W  = PATTERN_BYTES * BYTE_W;
	localparam int FILL_W = $clog2(PATTERN_BYTES + 1);

	// configuration
	cmp_cfg_t         cfg_q;
	logic [LEN_W-1:0] plen_q;
	logic [LEN_W-1:0] len_eff;

	// search state
	logic [WIN_W-1:0]  window_q;
	logic [FILL_W-1:0] fill_q;
	logic [WIN_W-1:0]  win_shift;
	logic [FILL_W-1:0] fill_inc;
	logic              has_result;

	// stage 1: window snapshot for the compare
	logic              v_s1;
	logic [WIN_W-1:0]  win_s1;
	logic [ADDR_W-1:0] addr_s1;

	// result register
	logic              out_v_q;
	hit_beat_t         out_q;

	logic accept;
	logic adv;
	logic hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes <= PATTERN_RST;
			cfg_q.mask_bytes    <= MASK_RST;
			plen_q              <= LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PATTERN: cfg_q.pattern_bytes <= cfg_wdata;
				REG_MASK:    cfg_q.mask_bytes    <= cfg_wdata;
				REG_LENGTH:  plen_q              <= cfg_wdata[LEN_W-1:0];
				default:     ;
			endcase
		end
	end

	// zero acts as one, anything beyond the window as the full window
	always_comb begin
		if (plen_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (plen_q > LEN_W'(PATTERN_BYTES)) begin
			len_eff = LEN_W'(PATTERN_BYTES);
		end else begin
			len_eff = plen_q;
		end
	end

	// newest byte enters at the top
	generate
		if (PATTERN_BYTES == 1) begin : g_one
			assign win_shift = bytes.data.mem_byte;
		end else begin : g_many
			assign win_shift = {bytes.data.mem_byte, window_q[WIN_W-1:BYTE_W]};
		end
	endgenerate

	assign fill_inc   = (fill_q < FILL_W'(PATTERN_BYTES)) ? fill_q + FILL_W'(1) : fill_q;
	assign has_result = LEN_W'(fill_inc) >= len_eff;

	assign adv         = !out_v_q || hits.ready;
	assign bytes.ready = !v_s1 || adv;
	assign accept      = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
		end else if (accept) begin
			// end of range empties the window after this byte is used
			if (bytes.data.last_byte) begin
				window_q <= '0;
				fill_q   <= '0;
			end else begin
				window_q <= win_shift;
				fill_q   <= fill_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= has_result;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_s1  <= win_shift;
			addr_s1 <= bytes.data.byte_addr - ADDR_W'(len_eff - LEN_W'(1));
		end
	end

	mph_match #(
		.PATTERN_BYTES(PATTERN_BYTES)
	) u_match (
		.win(win_s1),
		.len(len_eff),
		.cfg(cfg_q),
		.hit(hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			out_q.match_found <= hit;
			out_q.match_addr  <= addr_s1;
		end
	end

	assign hits.valid = out_v_q;
	assign hits.data  = out_q;

	// fill count never passes the window depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(PATTERN_BYTES))
		else $error("fill count beyond window depth");

	// a last byte leaves an empty window
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && bytes.data.last_byte |=> fill_q == '0)
		else $error("window not emptied after last byte");

	// a pending stage-1 result is not dropped while the output is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(addr_s1))
		else $error("stage-1 result lost under stall");

	// nothing enters while stage 1 is full and blocked
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |-> !bytes.ready)
		else $error("byte accepted over a blocked result");

endmodule

FILE: sv/mph_match.sv
module mph_match
	import mph_pkg::*;
#(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
	input  logic [PATTERN_BYTES*BYTE_W-1:0] win,
	input  logic [LEN_W-1:0]                len,
	input  cmp_cfg_t                        cfg,
	output logic                            hit
);

	localparam int WIN_W = PATTERN_BYTES * BYTE_W;

	logic [LEN_W-1:0]   skip;
	logic [LEN_W+2:0]   shamt;
	logic [WIN_W-1:0]   aligned;
	logic [PATTERN_BYTES-1:0] byte_ok;

	// oldest compared byte sits PATTERN_BYTES - len places above the bottom
	assign skip    = LEN_W'(PATTERN_BYTES) - len;
	assign shamt   = {skip, 3'b000};
	assign aligned = win >> shamt;

	always_comb begin
		for (int j = 0; j < PATTERN_BYTES; j++) begin
			byte_ok[j] = (LEN_W'(j) >= len) ||
				((aligned[BYTE_W*j +: BYTE_W] & cfg.mask_bytes[BYTE_W*j +: BYTE_W])
					== cfg.pattern_bytes[BYTE_W*j +: BYTE_W]);
		end
	end

	assign hit = &byte_ok;

endmodule
